FILE: rtl/mgf_pkg.sv
package mgf_pkg;

  // width of the saturated frame sum
  localparam int TOTAL_W = 32;

  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = 32'sh8000_0000;

  // operations of the shared adder
  typedef enum logic {
    ALU_ADD,
    ALU_AVG
  } alu_op_t;

endpackage

FILE: rtl/mgf_if.sv
interface mgf_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          frame_end;

  modport source (output valid, output sample, output frame_end, input ready);
  modport sink (input valid, input sample, input frame_end, output ready);
endinterface

interface mgf_out_if #(
  parameter int SAMPLE_BITS = 16
);
  import mgf_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] recovered;
  logic                          run_last;
  logic signed [TOTAL_W-1:0]     frame_total;

  modport source (output valid, output recovered, output run_last, output frame_total,
                  input ready);
  modport sink (input valid, input recovered, input run_last, input frame_total,
                output ready);
endinterface

FILE: rtl/mgf_alu.sv
module mgf_alu #(
  parameter int W = 22
) (
  input  mgf_pkg::alu_op_t op,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic signed [W-1:0] y
);
  import mgf_pkg::*;

  logic signed [W-1:0] sum;
  logic signed [W-1:0] adj;

  // truncating average: add one to a negative sum before the halving shift
  always_comb begin
    sum = a + b;
    adj = sum + $signed({{(W-1){1'b0}}, sum[W-1]});
    unique case (op)
      ALU_ADD: y = sum;
      ALU_AVG: y = adj >>> 1;
      default: y = sum;
    endcase
  end

endmodule

FILE: rtl/mgf_store.sv
module mgf_store #(
  parameter int W     = 16,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic                frame_we,
  input  logic [AW-1:0]       frame_waddr,
  input  logic signed [W-1:0] frame_wdata,
  input  logic                nv_we,
  input  logic [AW-1:0]       nv_waddr,
  input  logic signed [W-1:0] nv_wdata,
  input  logic [AW-1:0]       raddr,
  output logic signed [W-1:0] frame_rdata,
  output logic signed [W-1:0] nv_rdata
);

  // frame samples, overwritten in place with recovered values
  logic signed [W-1:0] frame_mem [DEPTH];
  // nearest valid value to the right of each interior position
  logic signed [W-1:0] nv_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[frame_waddr] <= frame_wdata;
    end
    frame_rdata <= frame_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (nv_we) begin
      nv_mem[nv_waddr] <= nv_wdata;
    end
    nv_rdata <= nv_mem[raddr];
  end

endmodule

FILE: rtl/missing_sample_gap_filler_core.sv
// sequence: items are loaded one at a time; after the item that closes a frame of n
//   samples it runs the backward scan (none below three samples), the fill pass,
//   saturation and the output pass; no new frame is taken until its last result is
//   taken, and each result is held until the sink takes it; the fill pass uses the
//   single shared adder, and all passes share the one registered store read port
// reset: synchronous active-high rst returns to loading with an empty frame
module missing_sample_gap_filler_core #(
  parameter int MAX_LEN     = 64,
  parameter int SAMPLE_BITS = 16
) (
  input logic      clk,
  input logic      rst,
  mgf_in_if.sink   samples,
  mgf_out_if.source results
);
  import mgf_pkg::*;

  localparam int S      = SAMPLE_BITS;
  localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int ACC_W  = S + IDX_W;
  localparam int SAT_W  = (ACC_W > TOTAL_W) ? ACC_W : TOTAL_W;

  // sequencer states
  localparam logic [3:0] LOAD     = 4'd0;
  localparam logic [3:0] SCAN_RD  = 4'd1;
  localparam logic [3:0] SCAN_WR  = 4'd2;
  localparam logic [3:0] FILL_RD  = 4'd3;
  localparam logic [3:0] FILL_AVG = 4'd4;
  localparam logic [3:0] FILL_ACC = 4'd5;
  localparam logic [3:0] SUM_SAT  = 4'd6;
  localparam logic [3:0] OUT_RD   = 4'd7;
  localparam logic [3:0] OUT_LD   = 4'd8;
  localparam logic [3:0] OUT_WAIT = 4'd9;

  logic [3:0]           state;
  // shared position: load count, scan index, fill index, output index
  logic [IDX_W-1:0]     pos;
  logic [IDX_W-1:0]     last_idx;

  // first sample recovery: first valid value seen so far
  logic signed [S-1:0]  f0;
  logic                 f0_ok;
  // last valid value among positions 1 .. pos-1
  logic signed [S-1:0]  lv;
  logic                 lv_ok;
  // recovered final sample
  logic signed [S-1:0]  fl;
  // running nearest valid value during the backward scan
  logic signed [S-1:0]  nearest;
  // last recovered value, left neighbor of the next one
  logic signed [S-1:0]  prev_f;
  logic signed [S-1:0]  f_reg;
  logic signed [ACC_W-1:0]   acc;
  logic signed [TOTAL_W-1:0] total;

  logic                 out_valid;
  logic signed [S-1:0]  out_sample;
  logic                 out_last;

  // load-side next values
  logic                 gap_in;
  logic                 end_now;
  logic signed [S-1:0]  f0_next;
  logic                 f0_ok_next;
  logic signed [S-1:0]  lv_next;
  logic                 lv_ok_next;
  logic signed [S-1:0]  fl_next;

  // store ports
  logic                 frame_we;
  logic signed [S-1:0]  frame_wdata;
  logic                 nv_we;
  logic [IDX_W-1:0]     rd_addr;
  logic signed [S-1:0]  frame_q;
  logic signed [S-1:0]  nv_q;

  // shared adder
  alu_op_t              alu_op;
  logic signed [ACC_W-1:0] alu_a;
  logic signed [ACC_W-1:0] alu_b;
  logic signed [ACC_W-1:0] alu_y;

  logic signed [S-1:0]  f_sel;
  logic signed [SAT_W-1:0] acc_x;
  logic signed [TOTAL_W-1:0] total_sat;

  mgf_store #(
    .W     (S),
    .DEPTH (MAX_LEN),
    .AW    (IDX_W)
  ) u_store (
    .clk         (clk),
    .frame_we    (frame_we),
    .frame_waddr (pos),
    .frame_wdata (frame_wdata),
    .nv_we       (nv_we),
    .nv_waddr    (pos),
    .nv_wdata    (nearest),
    .raddr       (rd_addr),
    .frame_rdata (frame_q),
    .nv_rdata    (nv_q)
  );

  mgf_alu #(
    .W (ACC_W)
  ) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  // handshake: items are taken only while loading
  assign samples.ready       = (state == LOAD);
  assign results.valid       = out_valid;
  assign results.recovered   = out_sample;
  assign results.run_last    = out_last;
  assign results.frame_total = total;

  // load bookkeeping: first valid sample, last valid interior sample, final sample fill
  always_comb begin
    gap_in     = &samples.sample;
    end_now    = samples.frame_end || (pos == IDX_W'(MAX_LEN - 1));
    f0_next    = f0;
    f0_ok_next = f0_ok;
    lv_next    = lv;
    lv_ok_next = lv_ok;
    if (pos == '0) begin
      f0_next    = gap_in ? '0 : samples.sample;
      f0_ok_next = !gap_in;
      lv_ok_next = 1'b0;
    end else begin
      if (!f0_ok && !gap_in) begin
        f0_next    = samples.sample;
        f0_ok_next = 1'b1;
      end
      if (!gap_in) begin
        lv_next    = samples.sample;
        lv_ok_next = 1'b1;
      end
    end
    // missing final sample: last valid interior value, else the recovered first sample
    fl_next = gap_in ? (lv_ok ? lv : f0_next) : samples.sample;
  end

  // store read address: next position is prefetched while the current one is used
  always_comb begin
    unique case (state)
      SCAN_WR:            rd_addr = pos - IDX_W'(1);
      FILL_ACC, OUT_WAIT: rd_addr = pos + IDX_W'(1);
      default:            rd_addr = pos;
    endcase
  end

  // store writes: loaded samples, then recovered values in place; nearest values in scan
  always_comb begin
    frame_we    = (state == LOAD && samples.valid) || (state == FILL_ACC);
    frame_wdata = (state == LOAD) ? samples.sample : f_reg;
    nv_we       = (state == SCAN_WR);
  end

  // adder use: averaging in FILL_AVG, frame sum accumulation in FILL_ACC
  always_comb begin
    if (state == FILL_ACC) begin
      alu_op = ALU_ADD;
      alu_a  = acc;
      alu_b  = ACC_W'(f_reg);
    end else begin
      alu_op = ALU_AVG;
      alu_a  = ACC_W'(prev_f);
      alu_b  = ACC_W'(nv_q);
    end
  end

  // recovered value of the current position
  always_comb begin
    priority if (pos == '0) begin
      f_sel = f0;
    end else if (pos == last_idx) begin
      f_sel = fl;
    end else if (&frame_q) begin
      f_sel = alu_y[S-1:0];
    end else begin
      f_sel = frame_q;
    end
  end

  // clamp the frame sum into the 32-bit signed range
  always_comb begin
    acc_x = SAT_W'(acc);
    priority if (acc_x > SAT_W'(TOTAL_MAX)) begin
      total_sat = TOTAL_MAX;
    end else if (acc_x < SAT_W'(TOTAL_MIN)) begin
      total_sat = TOTAL_MIN;
    end else begin
      total_sat = acc_x[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= LOAD;
      pos       <= '0;
      f0_ok     <= 1'b0;
      lv_ok     <= 1'b0;
      acc       <= '0;
      total     <= '0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      unique case (state)
        LOAD: begin
          if (samples.valid) begin
            f0    <= f0_next;
            f0_ok <= f0_ok_next;
            lv    <= lv_next;
            lv_ok <= lv_ok_next;
            if (end_now) begin
              last_idx <= pos;
              fl       <= fl_next;
              nearest  <= fl_next;
              acc      <= '0;
              // interior positions exist only for three or more samples
              if ({1'b0, pos} >= (IDX_W + 1)'(2)) begin
                pos   <= pos - IDX_W'(1);
                state <= SCAN_RD;
              end else begin
                pos   <= '0;
                state <= FILL_RD;
              end
            end else begin
              pos <= pos + IDX_W'(1);
            end
          end
        end
        SCAN_RD: begin
          state <= SCAN_WR;
        end
        SCAN_WR: begin
          // frame_q holds the original sample at pos
          if (!(&frame_q)) begin
            nearest <= frame_q;
          end
          if (pos == IDX_W'(1)) begin
            pos   <= '0;
            state <= FILL_RD;
          end else begin
            pos <= pos - IDX_W'(1);
          end
        end
        FILL_RD: begin
          state <= FILL_AVG;
        end
        FILL_AVG: begin
          f_reg <= f_sel;
          state <= FILL_ACC;
        end
        FILL_ACC: begin
          acc    <= alu_y;
          prev_f <= f_reg;
          if (pos == last_idx) begin
            pos   <= '0;
            state <= SUM_SAT;
          end else begin
            pos   <= pos + IDX_W'(1);
            state <= FILL_AVG;
          end
        end
        SUM_SAT: begin
          total <= total_sat;
          state <= OUT_RD;
        end
        OUT_RD: begin
          state <= OUT_LD;
        end
        OUT_LD: begin
          out_sample <= frame_q;
          out_last   <= (pos == last_idx);
          out_valid  <= 1'b1;
          state      <= OUT_WAIT;
        end
        OUT_WAIT: begin
          if (results.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              pos   <= '0;
              total <= '0;
              state <= LOAD;
            end else begin
              pos   <= pos + IDX_W'(1);
              state <= OUT_LD;
            end
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

endmodule

FILE: rtl/mgf_checker.sv
module mgf_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_frame_end,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_last,
  input logic [SAMPLE_BITS-1:0] out_recovered
);

  // no item is taken while results of a frame are pending
  a_no_load_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("item accepted while results pending");

  // a closing item stops intake: ready drops once it is taken
  a_stop_after_end: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_frame_end) |=> !in_ready)
    else $error("intake continued after frame end");

  // after the final result no result is valid and intake is open again
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> (!out_valid && in_ready))
    else $error("unexpected state after final result");

  // a stalled result holds its value
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_recovered)))
    else $error("stalled result changed");

endmodule

bind missing_sample_gap_filler_core mgf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mgf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (samples.valid),
  .in_ready      (samples.ready),
  .in_frame_end  (samples.frame_end),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .out_last      (results.run_last),
  .out_recovered (results.recovered)
);
